[src/ovl_pkg.sv]
// ovl_pkg: shared types, codes and sizes for the ordered value list
// used by every module of the block, no dependencies of its own
package ovl_pkg;

  // default list size and command queue depth
  localparam int OVL_LIST_DEPTH = 16;
  localparam int OVL_CMDQ_DEPTH = 2;
  localparam int OVL_VAL_W      = 32;

  // input opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EMPTY     = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  // decoded command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2
  } ovl_cmd_kind_t;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [OVL_VAL_W-1:0] value;
  } ovl_in_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [OVL_VAL_W-1:0] entry_value;
    logic                        last;
  } ovl_out_t;

  typedef struct packed {
    ovl_cmd_kind_t               kind;
    logic signed [OVL_VAL_W-1:0] value;
  } ovl_cmd_t;

  // command queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } ovl_q_stat_t;

endpackage

[src/ovl_front.sv]
// ovl_front: takes input beats, decodes the opcode and drops unused codes
// depends on ovl_pkg
module ovl_front import ovl_pkg::*; (
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  ovl_in_t     in_data,
  input  ovl_q_stat_t q_stat,
  output logic        q_push,
  output ovl_cmd_t    q_cmd
);

  logic cmd_valid;

  // opcode decode, the unused code gives no command
  always_comb begin
    cmd_valid   = 1'b1;
    q_cmd.value = in_data.value;
    case (in_data.opcode)
      OP_APPEND: q_cmd.kind = CMD_APPEND;
      OP_REMOVE: q_cmd.kind = CMD_REMOVE;
      OP_DUMP:   q_cmd.kind = CMD_DUMP;
      default: begin
        q_cmd.kind = CMD_APPEND;
        cmd_valid  = 1'b0;
      end
    endcase
  end

  // accept while the command queue has room
  assign full   = q_stat.full || !rst_n;
  assign q_push = push && !full && cmd_valid;

endmodule

[src/ovl_cmd_queue.sv]
// ovl_cmd_queue: short queue of decoded commands between front and back
// depends on ovl_pkg
module ovl_cmd_queue import ovl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_push,
  input  ovl_cmd_t    q_cmd,
  input  logic        q_pop,
  output ovl_cmd_t    q_head,
  output ovl_q_stat_t q_stat
);

  localparam int PW = (OVL_CMDQ_DEPTH > 1) ? $clog2(OVL_CMDQ_DEPTH) : 1;
  localparam int OW = $clog2(OVL_CMDQ_DEPTH + 1);

  ovl_cmd_t        slot_r [OVL_CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (occ_r == OW'(OVL_CMDQ_DEPTH));
  assign q_stat.empty = (occ_r == '0);
  assign do_push      = q_push && !q_stat.full;
  assign do_pop       = q_pop && !q_stat.empty;
  assign q_head       = slot_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(OVL_CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(OVL_CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      occ_nxt = occ_r + 1'b1;
    end else if (do_pop && !do_push) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_cmd;
    end
  end

endmodule

[src/ovl_back.sv]
// ovl_back: cell chain holding the list, executes commands, owns the result register
// depends on ovl_pkg
module ovl_back import ovl_pkg::*; #(
  parameter int LIST_DEPTH = OVL_LIST_DEPTH,
  localparam int CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ovl_cmd_t      q_head,
  input  ovl_q_stat_t   q_stat,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output ovl_out_t      out_data,
  output logic [CW-1:0] list_count,
  output logic          dumping
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } back_state_t;

  back_state_t                 state_r, state_nxt;
  logic signed [OVL_VAL_W-1:0] cell_r [LIST_DEPTH];
  logic signed [OVL_VAL_W-1:0] cell_nxt [LIST_DEPTH];
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ovl_out_t                    out_r, out_nxt;
  logic [LIST_DEPTH-1:0]       match_v;
  logic [LIST_DEPTH-1:0]       shift_en;
  logic                        any_match;
  logic                        can_emit;
  logic                        do_append, do_remove, do_rotate;

  assign can_emit   = !out_valid_r || pop;
  assign empty      = !out_valid_r;
  assign out_data   = out_r;
  assign list_count = count_r;
  assign dumping    = (state_r == ST_DUMP);

  // per-cell compare, and each cell finds whether a match sits at or ahead of it
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match_v[i] = (cell_r[i] == q_head.value) && (CW'(i) < count_r);
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      shift_en[i] = |(match_v & ({LIST_DEPTH{1'b1}} >> (LIST_DEPTH - 1 - i)));
    end
    any_match = |match_v;
  end

  // command sequencer and result formation
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    do_append     = 1'b0;
    do_remove     = 1'b0;
    do_rotate     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty && can_emit) begin
          out_valid_nxt       = 1'b1;
          out_nxt.entry_value = '0;
          out_nxt.last        = 1'b1;
          q_pop               = 1'b1;
          case (q_head.kind)
            CMD_APPEND: begin
              if (count_r == CW'(LIST_DEPTH)) begin
                out_nxt.status = STS_FULL;
              end else begin
                out_nxt.status = STS_OK;
                do_append      = 1'b1;
                count_nxt      = count_r + 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                out_nxt.status = STS_EMPTY;
              end else if (!any_match) begin
                out_nxt.status = STS_NOT_FOUND;
              end else begin
                out_nxt.status = STS_OK;
                do_remove      = 1'b1;
                count_nxt      = count_r - 1'b1;
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                out_nxt.status = STS_EMPTY;
              end else begin
                out_nxt.status      = STS_OK;
                out_nxt.entry_value = cell_r[0];
                do_rotate           = 1'b1;
                if (count_r != CW'(1)) begin
                  out_nxt.last = 1'b0;
                  q_pop        = 1'b0;
                  rem_nxt      = count_r - 1'b1;
                  state_nxt    = ST_DUMP;
                end
              end
            end
            default: begin
              out_nxt.status = STS_OK;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (can_emit) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = STS_OK;
          out_nxt.entry_value = cell_r[0];
          out_nxt.last        = (rem_r == CW'(1));
          do_rotate           = 1'b1;
          rem_nxt             = rem_r - 1'b1;
          if (rem_r == CW'(1)) begin
            q_pop     = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // cell chain: tail write, gap close on removal, rotate by one during a dump
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_append && (CW'(i) == count_r)) begin
        cell_nxt[i] = q_head.value;
      end
      if (do_remove && shift_en[i] && (i < LIST_DEPTH - 1)) begin
        cell_nxt[i] = cell_r[(i < LIST_DEPTH - 1) ? i + 1 : i];
      end
      if (do_rotate) begin
        if (CW'(i + 1) < count_r) begin
          cell_nxt[i] = cell_r[(i < LIST_DEPTH - 1) ? i + 1 : i];
        end else if (CW'(i + 1) == count_r) begin
          cell_nxt[i] = cell_r[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

endmodule

[src/ordered_value_list_core.sv]
// ordered_value_list_core: top level of the ordered value list
// depends on ovl_pkg, ovl_front, ovl_cmd_queue, ovl_back
//
//   channel  handshake    payload              beat accepted when
//   in       push / full  in_data  (ovl_in_t)  push && !full
//   out      empty / pop  out_data (ovl_out_t) pop && !empty
//
// append and remove each give one result beat; a dump gives one result beat per
// entry (one for an empty list), from the one-entry rotate of the cell chain
// the front takes a beat per cycle while the two-deep command queue has room
// reset clears count, queue and result valid flag; list cells and result payload are not cleared
// a stalled result holds the back end, which in turn fills the command queue
module ordered_value_list_core import ovl_pkg::*; #(
  parameter int LIST_DEPTH = OVL_LIST_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  ovl_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output ovl_out_t out_data
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  ovl_q_stat_t   q_stat;
  ovl_cmd_t      q_cmd, q_head;
  logic          q_push, q_pop;
  logic [CW-1:0] list_count;
  logic          dumping;

  // front: decode and classify
  ovl_front u_front (
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // queue between front and back
  ovl_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // back: cell chain and result register
  ovl_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .list_count (list_count),
    .dumping    (dumping)
  );

  // list never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    list_count <= CW'(LIST_DEPTH))
    else $error("list count above depth");

  // a multi-beat dump only runs over a non-empty list
  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    dumping |-> (list_count != '0))
    else $error("dump running on empty list");

  // entering a dump puts its first entry in the result register
  a_dump_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dumping) |-> !empty)
    else $error("dump started without a result beat");

endmodule

[dv/ordered_value_list_core_test.sv]
// ordered_value_list_core_test: self-checking bench for the ordered value list
// depends on ovl_pkg and ordered_value_list_core; a shadow list predicts every
// reply, directed commands first and then random traffic with idle bursts
module ordered_value_list_core_test;
  import ovl_pkg::*;

  localparam int LIST_DEPTH   = OVL_LIST_DEPTH;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_CMDS  = 330;
  localparam int QUIET_TAIL   = 60;
  // the one opcode that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     full;
  ovl_in_t  in_data = '0;
  logic     empty;
  logic     pop = 1'b0;
  ovl_out_t out_data;

  // shadow copy of the list, updated on each accepted command beat
  logic signed [31:0] shadow_vals [LIST_DEPTH];
  int                 shadow_count = 0;
  ovl_out_t           list_replies [$];

  bit idle_on = 1'b1;
  int stall_left = 0;
  int errors = 0;
  int n_cmds = 0;
  int n_replies = 0;
  int n_full_rejects = 0;
  int n_removed = 0;
  int n_dump_entries = 0;

  ordered_value_list_core #(.LIST_DEPTH(LIST_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // hard stop if the run hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void queue_reply(input logic [1:0] status,
                                      input logic signed [31:0] val,
                                      input logic last);
    ovl_out_t r;
    r.status      = status;
    r.entry_value = val;
    r.last        = last;
    list_replies.push_back(r);
  endfunction

  // work out the replies of one command and update the shadow list
  function automatic void apply_list_cmd(input ovl_in_t cmd);
    int i;
    int hit;
    hit = -1;
    case (cmd.opcode)
      OP_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          queue_reply(STS_FULL, '0, 1'b1);
          n_full_rejects++;
        end else begin
          shadow_vals[shadow_count] = cmd.value;
          shadow_count++;
          queue_reply(STS_OK, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < shadow_count; i++)
          if (hit < 0 && shadow_vals[i] == cmd.value) hit = i;
        if (shadow_count == 0) begin
          queue_reply(STS_EMPTY, '0, 1'b1);
        end else if (hit < 0) begin
          queue_reply(STS_NOT_FOUND, '0, 1'b1);
        end else begin
          // close the gap, later entries move one place toward the head
          for (i = hit; i < shadow_count - 1; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_count--;
          n_removed++;
          queue_reply(STS_OK, '0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (shadow_count == 0) begin
          queue_reply(STS_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            queue_reply(STS_OK, shadow_vals[i], (i == shadow_count - 1));
          n_dump_entries += shadow_count;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_reply(input ovl_out_t got);
    ovl_out_t want;
    if (list_replies.size() == 0) begin
      $error("unexpected reply: status %0d entry_value %0d last %0d",
             got.status, got.entry_value, got.last);
      errors++;
      return;
    end
    want = list_replies.pop_front();
    n_replies++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.entry_value !== want.entry_value) begin
      $error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endfunction

  // command beats are predicted before reply beats of the same edge are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        n_cmds++;
        apply_list_cmd(in_data);
      end
      if (pop && !empty) check_reply(out_data);
    end
  end

  // reply side: pop, with random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // offer one command beat, with an optional idle burst first
  task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] val);
    ovl_in_t cmd;
    cmd.opcode = op;
    cmd.value  = val;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (full);
  endtask

  task automatic test_empty_list();
    send_cmd(OP_REMOVE, 32'sh0000_0000);
    send_cmd(OP_DUMP, 32'sh0000_0000);
    send_cmd(OP_UNUSED, 32'shFFFF_FFFF);
  endtask

  // fill to the limit with extremes and duplicates, overflow it, then dump it
  task automatic test_fill_and_overflow();
    logic [31:0] pattern [16];
    int i;
    pattern = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0005,
                32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0F0F_0F0F,
                32'hF0F0_F0F0, 32'h0000_0005, 32'h7FFF_FFFE, 32'h0000_0100};
    for (i = 0; i < LIST_DEPTH; i++) send_cmd(OP_APPEND, pattern[i % 16]);
    send_cmd(OP_APPEND, 32'sh8000_0001);
    send_cmd(OP_DUMP, 32'sh0000_0000);
  endtask

  // a miss, then the first of several equal entries goes, then a dump
  task automatic test_remove_match();
    send_cmd(OP_REMOVE, 32'sh1234_5678);
    send_cmd(OP_REMOVE, 32'sh0000_0005);
    send_cmd(OP_DUMP, 32'shFFFF_FFFF);
  endtask

  function automatic logic signed [31:0] draw_value(input bit from_list);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
      default: begin
        if (from_list && shadow_count > 0)
          return shadow_vals[$urandom_range(0, shadow_count - 1)];
        return $urandom;
      end
    endcase
  endfunction

  // random traffic in stretches that lean toward filling or draining
  task automatic test_random_traffic(input int total);
    int sent;
    int seg_left;
    int append_pct;
    int pick;
    sent     = 0;
    seg_left = 0;
    append_pct = 50;
    while (sent < total) begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(20, 50);
        append_pct = ($urandom_range(0, 1) != 0) ? 70 : 30;
        idle_on    = (total - sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      end
      // no idling at all over the closing stretch
      if (total - sent <= QUIET_TAIL) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_cmd(OP_UNUSED, $urandom);
      end else begin
        if (pick < 11)
          send_cmd(OP_DUMP, $urandom);
        else if (pick < 11 + append_pct)
          send_cmd(OP_APPEND, draw_value(1'b0));
        else
          send_cmd(OP_REMOVE, draw_value(1'b1));
        sent++;
        seg_left--;
      end
    end
    idle_on = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_fill_and_overflow();
    test_remove_match();
    test_random_traffic(RANDOM_CMDS);
    push <= 1'b0;
    while (list_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d command beats and %0d checked reply beats", n_cmds, n_replies);
    $display("%0d appends refused when full, %0d entries removed, %0d dumped entries",
             n_full_rejects, n_removed, n_dump_entries);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
src/ovl_pkg.sv
src/ovl_front.sv
src/ovl_cmd_queue.sv
src/ovl_back.sv
src/ordered_value_list_core.sv
dv/ordered_value_list_core_test.sv
